// ===== hdl/swerve_drive_wheel_kinematics_top_defines.svh =====
// Assertion macros for the checker file of the swerve drive block.
// Plain concurrent assertions sampled on the rising clock edge, off during reset.
`ifndef SWERVE_DRIVE_WHEEL_KINEMATICS_TOP_DEFINES_SVH
`define SWERVE_DRIVE_WHEEL_KINEMATICS_TOP_DEFINES_SVH

// Condition that must hold in the same cycle as its trigger.
`define SDWK_ASSERT_NOW(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define SDWK_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hdl/sdwk_pkg.sv =====
// Package of the swerve drive kinematics block: widths, angle constants,
// the CORDIC arctangent table and the wheel word type. No dependencies.
`timescale 1ns / 1ps

package sdwk_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 17;
   localparam int PIPE_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

   // Datapath widths of the back end.
   localparam int XW = 40;
   localparam int ZW = 33;
   localparam int NW = 34;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_SPIN_X = 8'd0;
   localparam logic [7:0] CSR_SPIN_Y = 8'd1;

   localparam logic signed [15:0] SPIN_COEF_RESET = 16'sd23170;

   // Angles in centidegrees.
   localparam logic [15:0] DEG90_CD  = 16'd9000;
   localparam logic [15:0] DEG180_CD = 16'd18000;
   localparam logic [15:0] DEG270_CD = 16'd27000;
   localparam logic [15:0] DEG360_CD = 16'd36000;

   // Angles in 1/65536 centidegree for the CORDIC accumulator.
   localparam logic signed [ZW-1:0] DEG180_U = 33'sd1179648000;
   localparam logic signed [ZW-1:0] DEG360_U = 33'sd2359296000;

   // floor(2^32 / 36000), used to divide by the full circle.
   localparam logic [16:0] RECIP_36000 = 17'd119304;
   localparam logic [15:0] MAX_COUNTS_DIV = 16'd36000;

   // One wheel word passed from the front end to the back end.
   typedef struct packed {
      logic signed [17:0] vx;
      logic signed [17:0] vy;
      logic [15:0]        meas;
      logic               axis;
      logic [15:0]        axis_dir;
      logic [1:0]         idx;
      logic               last;
   } wheel_job_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // atan(2^-i) in 1/65536 centidegree.
   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 33'sd294912000;
         1:  v = 33'sd174096719;
         2:  v = 33'sd91987925;
         3:  v = 33'sd46694507;
         4:  v = 33'sd23437865;
         5:  v = 33'sd11730358;
         6:  v = 33'sd5866610;
         7:  v = 33'sd2933484;
         8:  v = 33'sd1466764;
         9:  v = 33'sd733385;
         10: v = 33'sd366693;
         11: v = 33'sd183346;
         12: v = 33'sd91673;
         13: v = 33'sd45837;
         14: v = 33'sd22918;
         15: v = 33'sd11459;
         16: v = 33'sd5730;
         17: v = 33'sd2865;
         18: v = 33'sd1432;
         19: v = 33'sd716;
         20: v = 33'sd358;
         21: v = 33'sd179;
         22: v = 33'sd90;
         23: v = 33'sd45;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/sdwk_front.sv =====
// Front end: accepts chassis commands and splits each into four wheel words.
// Depends on sdwk_pkg.
`timescale 1ns / 1ps

module sdwk_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_vel_x,
   input  logic signed [15:0]     req_vel_y,
   input  logic signed [15:0]     req_vel_spin,
   input  logic [15:0]            req_meas_angle_w0,
   input  logic [15:0]            req_meas_angle_w1,
   input  logic [15:0]            req_meas_angle_w2,
   input  logic [15:0]            req_meas_angle_w3,
   input  logic signed [15:0]     coef_x,
   input  logic signed [15:0]     coef_y,
   output logic                   job_valid,
   input  logic                   job_ready,
   output sdwk_pkg::wheel_job_type job
);

   // Input holding stage.
   logic               a_valid_ff;
   logic signed [15:0] a_vel_x_ff, a_vel_y_ff, a_vel_spin_ff;
   logic [15:0]        a_meas_ff [0:3];

   // Wheel sequencing stage.
   logic               b_valid_ff, b_valid_in;
   logic [1:0]         b_wheel_ff, b_wheel_in;
   logic signed [16:0] b_vx0_ff, b_vy0_ff;
   logic signed [32:0] b_prodx_ff, b_prody_ff;
   logic [15:0]        b_meas_ff [0:3];

   logic               push, b_done, b_load;
   logic signed [16:0] w_spin, vy0_a, vx0_a;
   logic signed [32:0] prodx_in, prody_in;
   logic signed [33:0] tx, ty;
   logic signed [17:0] sx, sy, vx, vy;
   logic [15:0]        meas_raw, meas_mod;

   assign push      = b_valid_ff && job_ready;
   assign b_done    = push && (b_wheel_ff == 2'd3);
   assign b_load    = a_valid_ff && (!b_valid_ff || b_done);
   assign req_ready = !a_valid_ff || b_load;

   // Hold the accepted word until the sequencer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         a_valid_ff <= 1'b1;
      end else if (b_load) begin
         a_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         a_vel_x_ff    <= req_vel_x;
         a_vel_y_ff    <= req_vel_y;
         a_vel_spin_ff <= req_vel_spin;
         a_meas_ff[0]  <= req_meas_angle_w0;
         a_meas_ff[1]  <= req_meas_angle_w1;
         a_meas_ff[2]  <= req_meas_angle_w2;
         a_meas_ff[3]  <= req_meas_angle_w3;
      end
   end

   // Negate y and spin, and scale the spin by both coefficients.
   always_comb begin
      vx0_a    = $signed({a_vel_x_ff[15], a_vel_x_ff});
      vy0_a    = -$signed({a_vel_y_ff[15], a_vel_y_ff});
      w_spin   = -$signed({a_vel_spin_ff[15], a_vel_spin_ff});
      prodx_in = w_spin * coef_x;
      prody_in = w_spin * coef_y;
   end

   // Sequencer state: one wheel per cycle while the queue accepts.
   always_comb begin
      b_valid_in = b_valid_ff;
      b_wheel_in = b_wheel_ff;
      if (b_load) begin
         b_valid_in = 1'b1;
         b_wheel_in = 2'd0;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (push) begin
         b_wheel_in = b_wheel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_wheel_ff <= 2'd0;
      end else begin
         b_valid_ff <= b_valid_in;
         b_wheel_ff <= b_wheel_in;
      end
      if (b_load) begin
         b_vx0_ff     <= vx0_a;
         b_vy0_ff     <= vy0_a;
         b_prodx_ff   <= prodx_in;
         b_prody_ff   <= prody_in;
         b_meas_ff[0] <= a_meas_ff[0];
         b_meas_ff[1] <= a_meas_ff[1];
         b_meas_ff[2] <= a_meas_ff[2];
         b_meas_ff[3] <= a_meas_ff[3];
      end
   end

   // Round the spin shares, apply the wheel signs, wrap the measured angle and classify the axes.
   always_comb begin
      tx = $signed({b_prodx_ff[32], b_prodx_ff}) + 34'sd16384;
      ty = $signed({b_prody_ff[32], b_prody_ff}) + 34'sd16384;
      sx = tx[32:15];
      sy = ty[32:15];
      vx = $signed({b_vx0_ff[16], b_vx0_ff}) + (b_wheel_ff[0] ? -sx : sx);
      vy = $signed({b_vy0_ff[16], b_vy0_ff}) + (b_wheel_ff[1] ? -sy : sy);
      meas_raw = b_meas_ff[b_wheel_ff];
      meas_mod = (meas_raw >= sdwk_pkg::DEG360_CD) ? meas_raw - sdwk_pkg::DEG360_CD : meas_raw;

      job.vx   = vx;
      job.vy   = vy;
      job.meas = meas_mod;
      job.idx  = b_wheel_ff;
      job.last = (b_wheel_ff == 2'd3);
      if (vx == 18'sd0) begin
         job.axis     = 1'b1;
         job.axis_dir = (vy < 18'sd0) ? sdwk_pkg::DEG180_CD : 16'd0;
      end else if (vy == 18'sd0) begin
         job.axis     = 1'b1;
         job.axis_dir = (vx > 18'sd0) ? sdwk_pkg::DEG90_CD : sdwk_pkg::DEG270_CD;
      end else begin
         job.axis     = 1'b0;
         job.axis_dir = 16'd0;
      end
   end

   assign job_valid = b_valid_ff;

endmodule

// ===== hdl/sdwk_queue.sv =====
// Short queue of wheel words between the front end and the back end.
// Depends on sdwk_pkg.
`timescale 1ns / 1ps

module sdwk_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_valid,
   output logic                    wr_ready,
   input  sdwk_pkg::wheel_job_type wr_data,
   output logic                    rd_valid,
   input  logic                    rd_ready,
   output sdwk_pkg::wheel_job_type rd_data
);

   sdwk_pkg::wheel_job_type       entry_ff [0:sdwk_pkg::QUEUE_DEPTH-1];
   logic [sdwk_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [sdwk_pkg::QPTR_W:0]     count_ff, count_in;
   logic                          do_wr, do_rd;

   assign wr_ready = (count_ff != (sdwk_pkg::QPTR_W+1)'(sdwk_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;
   assign rd_data  = entry_ff[rd_ptr_ff];

   // Occupancy follows the two handshakes.
   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hdl/sdwk_back.sv =====
// Back end: pipelined square root and CORDIC per wheel, then steering fold
// and count scaling into the output register. Depends on sdwk_pkg.
`timescale 1ns / 1ps

module sdwk_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  sdwk_pkg::wheel_job_type job,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_wheel_index,
   output logic signed [17:0]      rsp_wheel_speed,
   output logic [11:0]             rsp_target_counts,
   output logic signed [14:0]      rsp_steer_error,
   output logic                    rsp_last_wheel
);

   typedef struct packed {
      logic [sdwk_pkg::NW-1:0]        n;
      logic [sdwk_pkg::NW-1:0]        r;
      logic signed [sdwk_pkg::XW-1:0] x;
      logic signed [sdwk_pkg::XW-1:0] y;
      logic signed [sdwk_pkg::ZW-1:0] z;
      logic [15:0]                    meas;
      logic                           axis;
      logic [15:0]                    axis_dir;
      logic [1:0]                     idx;
      logic                           last;
   } stage_type;

   // One square root bit and, for the first CORDIC_STEPS steps, one CORDIC rotation.
   function automatic stage_type step(input stage_type s, input int i);
      stage_type                      o;
      logic [sdwk_pkg::NW-1:0]        bitv;
      logic [sdwk_pkg::NW-1:0]        trial;
      logic signed [sdwk_pkg::XW-1:0] dx;
      logic signed [sdwk_pkg::XW-1:0] dy;
      o = s;
      if (i < sdwk_pkg::SQRT_STEPS) begin
         bitv  = sdwk_pkg::NW'(1) << (2 * (sdwk_pkg::SQRT_STEPS - 1 - i));
         trial = s.r + bitv;
         if (s.n >= trial) begin
            o.n = s.n - trial;
            o.r = (s.r >> 1) + bitv;
         end else begin
            o.r = s.r >> 1;
         end
      end
      if (i < sdwk_pkg::CORDIC_STEPS) begin
         dx = $signed(s.y) >>> i;
         dy = $signed(s.x) >>> i;
         if ($signed(s.y) > 0) begin
            o.x = $signed(s.x) + dx;
            o.y = $signed(s.y) - dy;
            o.z = $signed(s.z) + sdwk_pkg::atan_entry(i);
         end else begin
            o.x = $signed(s.x) - dx;
            o.y = $signed(s.y) + dy;
            o.z = $signed(s.z) - sdwk_pkg::atan_entry(i);
         end
      end
      return o;
   endfunction

   logic      adv;
   stage_type stg_ff [0:sdwk_pkg::PIPE_STEPS];
   logic      stg_valid_ff [0:sdwk_pkg::PIPE_STEPS];
   stage_type entry_in;

   logic signed [35:0]              sqx, sqy;
   logic signed [sdwk_pkg::XW-1:0]  xe, ye;

   // The whole pipeline moves whenever the output register can take a word.
   assign adv       = !rsp_valid || rsp_ready;
   assign job_ready = adv;

   // Entry: squared length and the CORDIC start vector.
   always_comb begin
      sqx = job.vx * job.vx;
      sqy = job.vy * job.vy;
      xe  = $signed({{(sdwk_pkg::XW-18){job.vy[17]}}, job.vy}) <<< 20;
      ye  = $signed({{(sdwk_pkg::XW-18){job.vx[17]}}, job.vx}) <<< 20;
      entry_in.n        = sqx[sdwk_pkg::NW-1:0] + sqy[sdwk_pkg::NW-1:0];
      entry_in.r        = '0;
      entry_in.meas     = job.meas;
      entry_in.axis     = job.axis;
      entry_in.axis_dir = job.axis_dir;
      entry_in.idx      = job.idx;
      entry_in.last     = job.last;
      if (xe < 0) begin
         entry_in.x = -xe;
         entry_in.y = -ye;
         entry_in.z = sdwk_pkg::DEG180_U;
      end else begin
         entry_in.x = xe;
         entry_in.y = ye;
         entry_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         stg_valid_ff[0] <= job_valid;
      end
      if (adv) begin
         stg_ff[0] <= entry_in;
      end
   end

   // Iteration stages.
   for (genvar gi = 0; gi < sdwk_pkg::PIPE_STEPS; gi++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[gi+1] <= 1'b0;
         end else if (adv) begin
            stg_valid_ff[gi+1] <= stg_valid_ff[gi];
         end
         if (adv) begin
            stg_ff[gi+1] <= step(stg_ff[gi], gi);
         end
      end
   end

   // Post stage one: wrap and round the direction or take the axis direction, round and saturate the magnitude.
   logic                           p1_valid_ff;
   logic [15:0]                    p1_dir_ff, p1_dir_in, p1_meas_ff;
   logic [16:0]                    p1_mag_ff, p1_mag_in;
   logic [1:0]                     p1_idx_ff;
   logic                           p1_last_ff;
   logic signed [sdwk_pkg::ZW-1:0] z1;
   logic [sdwk_pkg::ZW-1:0]        zsum;
   logic [15:0]                    zc;
   logic [sdwk_pkg::NW-1:0]        root;
   stage_type                      sl;

   always_comb begin
      sl   = stg_ff[sdwk_pkg::PIPE_STEPS];
      z1   = ($signed(sl.z) < 0) ? $signed(sl.z) + sdwk_pkg::DEG360_U : $signed(sl.z);
      zsum = z1 + sdwk_pkg::ZW'(32768);
      zc   = zsum[31:16];
      if (sl.axis) begin
         p1_dir_in = sl.axis_dir;
      end else if (zc >= sdwk_pkg::DEG360_CD) begin
         p1_dir_in = zc - sdwk_pkg::DEG360_CD;
      end else begin
         p1_dir_in = zc;
      end
      root      = (sl.n > sl.r) ? sl.r + 1'b1 : sl.r;
      p1_mag_in = (root > sdwk_pkg::NW'(131071)) ? 17'h1ffff : root[16:0];
   end

   // Post stage two: steering fold and scaled direction.
   logic                 p2_valid_ff;
   logic signed [17:0]   p2_speed_ff, p2_speed_in;
   logic signed [14:0]   p2_gap_ff;
   logic [27:0]          p2_p_ff, p2_p_in;
   logic [1:0]           p2_idx_ff;
   logic                 p2_last_ff;
   logic signed [16:0]   gap;
   logic signed [16:0]   g;
   logic                 rev;

   always_comb begin
      gap = $signed({1'b0, p1_dir_ff}) - $signed({1'b0, p1_meas_ff});
      g   = gap;
      rev = 1'b0;
      if (g > 17'sd27000) begin
         g = g - 17'sd36000;
      end else if (g > 17'sd9000) begin
         g   = g - 17'sd18000;
         rev = 1'b1;
      end
      if (g < -17'sd27000) begin
         g = g + 17'sd36000;
      end else if (g < -17'sd9000) begin
         g   = g + 17'sd18000;
         rev = !rev;
      end
      p2_speed_in = rev ? -$signed({1'b0, p1_mag_ff}) : $signed({1'b0, p1_mag_ff});
      p2_p_in     = {p1_dir_ff, 12'd0} - {12'd0, p1_dir_ff};
   end

   // Post stage three: quotient estimate by reciprocal multiplication.
   logic                 p3_valid_ff;
   logic signed [17:0]   p3_speed_ff;
   logic signed [14:0]   p3_gap_ff;
   logic [27:0]          p3_p_ff;
   logic [11:0]          p3_q_ff;
   logic [1:0]           p3_idx_ff;
   logic                 p3_last_ff;
   logic [44:0]          qprod;

   assign qprod = p2_p_ff * sdwk_pkg::RECIP_36000;

   // Output stage: one correction step of the quotient.
   logic [27:0] rem;
   logic [11:0] q_fix;

   always_comb begin
      rem   = p3_p_ff - (28'(p3_q_ff) * 28'(sdwk_pkg::MAX_COUNTS_DIV));
      q_fix = (rem >= 28'(sdwk_pkg::MAX_COUNTS_DIV)) ? p3_q_ff + 12'd1 : p3_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= stg_valid_ff[sdwk_pkg::PIPE_STEPS];
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         rsp_valid   <= p3_valid_ff;
      end
      if (adv) begin
         p1_dir_ff         <= p1_dir_in;
         p1_mag_ff         <= p1_mag_in;
         p1_meas_ff        <= sl.meas;
         p1_idx_ff         <= sl.idx;
         p1_last_ff        <= sl.last;
         p2_speed_ff       <= p2_speed_in;
         p2_gap_ff         <= g[14:0];
         p2_p_ff           <= p2_p_in;
         p2_idx_ff         <= p1_idx_ff;
         p2_last_ff        <= p1_last_ff;
         p3_speed_ff       <= p2_speed_ff;
         p3_gap_ff         <= p2_gap_ff;
         p3_p_ff           <= p2_p_ff;
         p3_q_ff           <= qprod[43:32];
         p3_idx_ff         <= p2_idx_ff;
         p3_last_ff        <= p2_last_ff;
         rsp_wheel_speed   <= p3_speed_ff;
         rsp_steer_error   <= p3_gap_ff;
         rsp_target_counts <= q_fix;
         rsp_wheel_index   <= p3_idx_ff;
         rsp_last_wheel    <= p3_last_ff;
      end
   end

endmodule

// ===== hdl/swerve_drive_wheel_kinematics_top.sv =====
// A command passes the front end's holding and sequencing registers, the queue,
// the back end's entry register, iteration and post stages into the output
// register. Each command becomes four wheel words on the single result channel,
// one per cycle while not stalled; a next command can be accepted while they are sent.
// Reset is synchronous and active high: it empties the pipeline and queue and
// loads both spin coefficients with 23170.
`timescale 1ns / 1ps

module swerve_drive_wheel_kinematics_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic signed [15:0] req_vel_spin,
   input  logic [15:0]        req_meas_angle_w0,
   input  logic [15:0]        req_meas_angle_w1,
   input  logic [15:0]        req_meas_angle_w2,
   input  logic [15:0]        req_meas_angle_w3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_wheel_index,
   output logic signed [17:0] rsp_wheel_speed,
   output logic [11:0]        rsp_target_counts,
   output logic signed [14:0] rsp_steer_error,
   output logic               rsp_last_wheel,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_data
);

   logic signed [15:0] coef_x_ff, coef_y_ff;
   logic               fj_valid, fj_ready, bj_valid, bj_ready;
   sdwk_pkg::wheel_job_type fj, bj;

   // Configuration registers; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff <= sdwk_pkg::SPIN_COEF_RESET;
         coef_y_ff <= sdwk_pkg::SPIN_COEF_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == sdwk_pkg::CSR_SPIN_X) begin
            coef_x_ff <= $signed(csr_data);
         end else if (csr_index == sdwk_pkg::CSR_SPIN_Y) begin
            coef_y_ff <= $signed(csr_data);
         end
      end
   end

   sdwk_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_vel_x         (req_vel_x),
      .req_vel_y         (req_vel_y),
      .req_vel_spin      (req_vel_spin),
      .req_meas_angle_w0 (req_meas_angle_w0),
      .req_meas_angle_w1 (req_meas_angle_w1),
      .req_meas_angle_w2 (req_meas_angle_w2),
      .req_meas_angle_w3 (req_meas_angle_w3),
      .coef_x            (coef_x_ff),
      .coef_y            (coef_y_ff),
      .job_valid         (fj_valid),
      .job_ready         (fj_ready),
      .job               (fj)
   );

   sdwk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fj_valid),
      .wr_ready (fj_ready),
      .wr_data  (fj),
      .rd_valid (bj_valid),
      .rd_ready (bj_ready),
      .rd_data  (bj)
   );

   sdwk_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (bj_valid),
      .job_ready         (bj_ready),
      .job               (bj),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_wheel_index   (rsp_wheel_index),
      .rsp_wheel_speed   (rsp_wheel_speed),
      .rsp_target_counts (rsp_target_counts),
      .rsp_steer_error   (rsp_steer_error),
      .rsp_last_wheel    (rsp_last_wheel)
   );

endmodule

// ===== hdl/sdwk_checker.sv =====
// Port-level checker for the swerve drive block, bound to the top level.
// Depends on swerve_drive_wheel_kinematics_top_defines.svh.
`timescale 1ns / 1ps
`include "swerve_drive_wheel_kinematics_top_defines.svh"

module sdwk_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_wheel_index,
   input logic signed [17:0] rsp_wheel_speed,
   input logic [11:0]        rsp_target_counts,
   input logic signed [14:0] rsp_steer_error,
   input logic               rsp_last_wheel
);

   // A stalled word stays put.
   `SDWK_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_wheel_speed) && $stable(rsp_wheel_index), "stalled result word changed")

   // The last flag marks wheel three and nothing else.
   `SDWK_ASSERT_NOW(a_last, clock, reset, rsp_valid, rsp_last_wheel == (rsp_wheel_index == 2'd3), "last flag does not match wheel three")

   // Wheels of one command come out in order.
   `SDWK_ASSERT_NEXT(a_order, clock, reset, rsp_valid && rsp_ready && !rsp_last_wheel, !rsp_valid || (rsp_wheel_index == $past(rsp_wheel_index) + 2'd1), "wheel order broken")

   // Encoder counts stay below a full turn.
   `SDWK_ASSERT_NOW(a_counts, clock, reset, rsp_valid, rsp_target_counts <= 12'd4094, "target counts out of range")

   // The folded steering error never exceeds a quarter turn.
   `SDWK_ASSERT_NOW(a_gap, clock, reset, rsp_valid, (rsp_steer_error >= -15'sd9000) && (rsp_steer_error <= 15'sd9000), "steering error out of range")

endmodule

bind swerve_drive_wheel_kinematics_top sdwk_checker u_sdwk_checker (.*);
